// ----- src/ttx_pkg.sv -----
// Package: shared types, constants and glyph tables of the enhancement triplet decoder.
package ttx_pkg;

	localparam int unsigned FILLER_MASK = 11'h7FF;
	localparam logic [4:0] MODE_ROW_SET_A = 5'd1;
	localparam logic [4:0] MODE_ROW_SET_B = 5'd4;
	localparam logic [4:0] MODE_ROW_ZERO = 5'd7;
	localparam logic [4:0] MODE_G2 = 5'd15;
	localparam logic [5:0] ROW_ADDR_BASE = 6'd40;
	localparam logic [5:0] ROW_ADDR_ZERO = 6'd63;
	localparam logic [4:0] LAST_ROW = 5'd24;

	// Operation kinds passed from the front part to the back part.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_G2,
		OP_COMPOSE
	} op_t;

	// One classified triplet, as held in the queue.
	typedef struct packed {
		op_t op;
		logic [4:0] row;
		logic [5:0] column;
		logic [3:0] mark;
		logic [6:0] data;
	} item_t;

	// G2 glyph, Latin-1 (data 32..127).
	function automatic logic [7:0] g2_lat1(input logic [6:0] d);
		logic [7:0] g;
		unique case (d)
			7'd33: g = 8'hA1; 7'd34: g = 8'hA2; 7'd35: g = 8'hA3; 7'd36: g = 8'h24;
			7'd37: g = 8'hA5; 7'd38: g = 8'h23; 7'd39: g = 8'hA7; 7'd40: g = 8'hA4;
			7'd41: g = 8'h27; 7'd42: g = 8'h22; 7'd43: g = 8'hAB;
			7'd48: g = 8'hB0; 7'd49: g = 8'hB1; 7'd50: g = 8'hB2; 7'd51: g = 8'hB3;
			7'd52: g = 8'hD7; 7'd53: g = 8'hB5; 7'd54: g = 8'hB6; 7'd55: g = 8'hB7;
			7'd56: g = 8'hF7; 7'd57: g = 8'h27; 7'd58: g = 8'h22; 7'd59: g = 8'hBB;
			7'd60: g = 8'hBC; 7'd61: g = 8'hBD; 7'd62: g = 8'hBE; 7'd63: g = 8'hBF;
			7'd65: g = 8'h60; 7'd66: g = 8'hB4; 7'd67: g = 8'h5E; 7'd68: g = 8'h7E;
			7'd72: g = 8'hA8; 7'd73: g = 8'h2E; 7'd74: g = 8'hB0; 7'd75: g = 8'hB8;
			7'd76: g = 8'h5F; 7'd77: g = 8'h22;
			7'd80: g = 8'h5F; 7'd81: g = 8'hB9; 7'd82: g = 8'hAE; 7'd83: g = 8'hA9;
			7'd97: g = 8'hC6; 7'd98: g = 8'hD0; 7'd99: g = 8'hAA; 7'd100: g = 8'h48;
			7'd102: g = 8'h49; 7'd103: g = 8'h4C; 7'd104: g = 8'h4C; 7'd105: g = 8'hD8;
			7'd107: g = 8'hBA; 7'd108: g = 8'hDE; 7'd109: g = 8'h54; 7'd110: g = 8'h4E;
			7'd111: g = 8'h6E; 7'd112: g = 8'h4B; 7'd113: g = 8'hE6; 7'd114: g = 8'h64;
			7'd115: g = 8'hF0; 7'd116: g = 8'h68; 7'd117: g = 8'h69; 7'd118: g = 8'h69;
			7'd119: g = 8'h6C; 7'd120: g = 8'h6C; 7'd121: g = 8'hF8; 7'd123: g = 8'hDF;
			7'd124: g = 8'hFE; 7'd125: g = 8'h74; 7'd126: g = 8'h6E; 7'd127: g = 8'h7F;
			default: g = 8'h20;
		endcase
		return g;
	endfunction

	// G2 glyph, Latin-2 (data 32..127).
	function automatic logic [7:0] g2_lat2(input logic [6:0] d);
		logic [7:0] g;
		unique case (d)
			7'd33: g = 8'h69; 7'd34: g = 8'h63; 7'd35: g = 8'h4C; 7'd36: g = 8'h24;
			7'd37: g = 8'h59; 7'd38: g = 8'h23; 7'd39: g = 8'hA7; 7'd40: g = 8'hA4;
			7'd41: g = 8'h27; 7'd42: g = 8'h22; 7'd43: g = 8'h3C;
			7'd48: g = 8'hB0; 7'd52: g = 8'hD7; 7'd53: g = 8'h75; 7'd56: g = 8'hF7;
			7'd57: g = 8'h27; 7'd58: g = 8'h22; 7'd59: g = 8'h3E;
			7'd65: g = 8'h60; 7'd66: g = 8'hB4; 7'd67: g = 8'h5E; 7'd68: g = 8'h7E;
			7'd70: g = 8'hA2; 7'd71: g = 8'hFF; 7'd72: g = 8'hA8; 7'd73: g = 8'h2E;
			7'd74: g = 8'hB0; 7'd75: g = 8'hB8; 7'd76: g = 8'h5F; 7'd77: g = 8'hBD;
			7'd78: g = 8'hB2; 7'd79: g = 8'hB7;
			7'd80: g = 8'h2D; 7'd82: g = 8'h52; 7'd83: g = 8'h43;
			7'd98: g = 8'hD0; 7'd99: g = 8'h61; 7'd100: g = 8'h48; 7'd102: g = 8'h69;
			7'd103: g = 8'h4C; 7'd104: g = 8'hA3; 7'd105: g = 8'h4F; 7'd107: g = 8'h6F;
			7'd108: g = 8'h70; 7'd109: g = 8'h54; 7'd110: g = 8'h4E; 7'd111: g = 8'h6E;
			7'd112: g = 8'h4B; 7'd114: g = 8'hF0; 7'd115: g = 8'h64; 7'd116: g = 8'h68;
			7'd117: g = 8'h69; 7'd118: g = 8'h69; 7'd119: g = 8'h6C; 7'd120: g = 8'hB3;
			7'd121: g = 8'h6F; 7'd123: g = 8'hDF; 7'd124: g = 8'h70; 7'd125: g = 8'h74;
			7'd126: g = 8'h6E; 7'd127: g = 8'h7F;
			default: g = 8'h20;
		endcase
		return g;
	endfunction

	// Composition of a G0 character with a diacritical mark; {lat1, lat2}.
	// Characters without an entry for the mark pass through unchanged.
	function automatic logic [15:0] compose(input logic [3:0] m, input logic [6:0] c);
		logic [15:0] r;
		r = {1'b0, c, 1'b0, c};
		unique case (m)
			4'd0: if (c == "#") r = {8'hA4, 8'h24};
			4'd1: begin
				unique case (c)
					" ": r = {8'h60, 8'h60}; "a": r = {8'hE0, 8'h61}; "e": r = {8'hE8, 8'h65};
					"i": r = {8'hEC, 8'h69}; "o": r = {8'hF2, 8'h6F}; "u": r = {8'hF9, 8'h75};
					"A": r = {8'hC0, 8'h41}; "E": r = {8'hC8, 8'h45}; "I": r = {8'hCC, 8'h49};
					"O": r = {8'hD2, 8'h4F}; "U": r = {8'hD9, 8'h55};
					default: ;
				endcase
			end
			4'd2: begin
				unique case (c)
					" ": r = {8'h27, 8'h27}; "a": r = {8'hE1, 8'hE1}; "c": r = {8'h63, 8'hE6};
					"e": r = {8'hE9, 8'hE9}; "i": r = {8'hED, 8'hED}; "l": r = {8'h6C, 8'hE5};
					"n": r = {8'h6E, 8'hF1}; "o": r = {8'hF3, 8'hF3}; "r": r = {8'h72, 8'hE0};
					"s": r = {8'h73, 8'hB6}; "u": r = {8'hFA, 8'hFA}; "y": r = {8'hFD, 8'hFD};
					"z": r = {8'h7A, 8'hBC}; "A": r = {8'hC1, 8'hC1}; "C": r = {8'h43, 8'hC6};
					"E": r = {8'hC9, 8'hC9}; "I": r = {8'hCD, 8'hCD}; "L": r = {8'h4C, 8'hC5};
					"N": r = {8'h4E, 8'hD1}; "O": r = {8'hD3, 8'hD3}; "R": r = {8'h52, 8'hC0};
					"S": r = {8'h53, 8'hA6}; "U": r = {8'hDA, 8'hDA}; "Y": r = {8'hDD, 8'hDD};
					"Z": r = {8'h5A, 8'hAC};
					default: ;
				endcase
			end
			4'd3: begin
				unique case (c)
					" ": r = {8'h5E, 8'h5E}; "a": r = {8'hE2, 8'hE2}; "e": r = {8'hEA, 8'h65};
					"i": r = {8'hEE, 8'hEE}; "o": r = {8'hF4, 8'hF4}; "u": r = {8'hFB, 8'h75};
					"A": r = {8'hC2, 8'hC2}; "E": r = {8'hCA, 8'h45}; "I": r = {8'hCE, 8'hCE};
					"O": r = {8'hD4, 8'hD4}; "U": r = {8'hDB, 8'h55};
					default: ;
				endcase
			end
			4'd4: begin
				unique case (c)
					" ": r = {8'h7E, 8'h7E}; "a": r = {8'hE3, 8'h61}; "n": r = {8'hF1, 8'h6E};
					"o": r = {8'hF5, 8'h6F}; "A": r = {8'hC3, 8'h41}; "N": r = {8'hD1, 8'h4E};
					"O": r = {8'hD5, 8'h4F};
					default: ;
				endcase
			end
			4'd6: begin
				if (c == "a") r = {8'h61, 8'hE3};
				else if (c == "A") r = {8'h41, 8'hC3};
			end
			4'd7: begin
				if (c == "z") r = {8'h7A, 8'hBF};
				else if (c == "Z") r = {8'h5A, 8'hAF};
			end
			4'd8: begin
				unique case (c)
					"a": r = {8'hE4, 8'hE4}; "e": r = {8'hEB, 8'hEB}; "i": r = {8'hEF, 8'h69};
					"o": r = {8'hF6, 8'hF6}; "u": r = {8'hFC, 8'hFC}; "A": r = {8'hC4, 8'hC4};
					"E": r = {8'hCB, 8'hCB}; "I": r = {8'hCF, 8'h49}; "O": r = {8'hD6, 8'hD6};
					"U": r = {8'hDC, 8'hDC};
					default: ;
				endcase
			end
			4'd10: begin
				unique case (c)
					" ": r = {8'hB0, 8'hB0}; "a": r = {8'hE5, 8'h61}; "u": r = {8'h75, 8'hF9};
					"A": r = {8'hC5, 8'h41}; "U": r = {8'h55, 8'hD9};
					default: ;
				endcase
			end
			4'd11: begin
				unique case (c)
					"c": r = {8'hE7, 8'hE7}; "s": r = {8'h73, 8'hBA}; "t": r = {8'h74, 8'hFE};
					"C": r = {8'hC7, 8'hC7}; "S": r = {8'h53, 8'hAA}; "T": r = {8'h54, 8'hDE};
					default: ;
				endcase
			end
			4'd12: if (c == " ") r = {8'h5F, 8'h5F};
			4'd13: begin
				unique case (c)
					" ": r = {8'h22, 8'h22}; "o": r = {8'h6F, 8'hF5}; "u": r = {8'h75, 8'hFB};
					"O": r = {8'h4F, 8'hD5}; "U": r = {8'h55, 8'hDB};
					default: ;
				endcase
			end
			4'd14: begin
				unique case (c)
					"a": r = {8'h61, 8'hB1}; "e": r = {8'h65, 8'hEA};
					"A": r = {8'h41, 8'hA1}; "E": r = {8'h45, 8'hCA};
					default: ;
				endcase
			end
			4'd15: begin
				unique case (c)
					"c": r = {8'h63, 8'hE8}; "d": r = {8'h64, 8'hEF}; "e": r = {8'h65, 8'hEC};
					"l": r = {8'h6C, 8'hB5}; "n": r = {8'h6E, 8'hF2}; "r": r = {8'h72, 8'hF8};
					"s": r = {8'h73, 8'hB9}; "t": r = {8'h74, 8'hBB}; "z": r = {8'h7A, 8'hBE};
					"C": r = {8'h43, 8'hC8}; "D": r = {8'h44, 8'hCF}; "E": r = {8'h45, 8'hCC};
					"L": r = {8'h4C, 8'hA5}; "N": r = {8'h4E, 8'hD2}; "R": r = {8'h52, 8'hD8};
					"S": r = {8'h53, 8'hA9}; "T": r = {8'h54, 8'hAB}; "Z": r = {8'h5A, 8'hAE};
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

endpackage

// ----- src/ttx_front.sv -----
// Front part: accepts triplets, tracks the current row and classifies each triplet.
module ttx_front #(
	parameter int PAGE_COLUMNS = 40,
	parameter int PAGE_ROWS = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [17:0] triplet_word,
	input  logic start_of_set,
	output logic in_ready,
	output logic push,
	output ttx_pkg::item_t push_item,
	input  logic q_full
);
	logic [4:0] current_row_q;
	logic [5:0] adr;
	logic [4:0] mode;
	logic [6:0] data;
	logic [4:0] row_eff;
	logic [4:0] row_addr;
	logic filler;
	logic fire;

	assign in_ready = !q_full;
	assign fire = in_valid && in_ready;
	assign adr = triplet_word[5:0];
	assign mode = triplet_word[10:6];
	assign data = triplet_word[17:11];
	assign filler = (triplet_word[10:0] == 11'(ttx_pkg::FILLER_MASK));
	assign row_eff = start_of_set ? 5'd0 : current_row_q;
	assign row_addr = (adr == ttx_pkg::ROW_ADDR_BASE) ? ttx_pkg::LAST_ROW
		: 5'(adr - ttx_pkg::ROW_ADDR_BASE);

	// Classify: only in-page character writes go into the queue.
	always_comb begin
		push_item.row = row_eff;
		push_item.column = adr;
		push_item.mark = mode[3:0];
		push_item.data = data;
		push_item.op = ttx_pkg::OP_NONE;
		if (!filler && adr < ttx_pkg::ROW_ADDR_BASE && 32'(adr) < PAGE_COLUMNS
			&& 32'(row_eff) < PAGE_ROWS) begin
			if (mode == ttx_pkg::MODE_G2 && data[6:5] != 2'b00)
				push_item.op = ttx_pkg::OP_G2;
			else if (mode[4])
				push_item.op = ttx_pkg::OP_COMPOSE;
		end
	end
	assign push = fire && push_item.op != ttx_pkg::OP_NONE;

	// Current row update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_row_q <= 5'd0;
		end else if (fire) begin
			current_row_q <= row_eff;
			if (!filler && adr >= ttx_pkg::ROW_ADDR_BASE) begin
				if (mode == ttx_pkg::MODE_ROW_SET_A || mode == ttx_pkg::MODE_ROW_SET_B)
					current_row_q <= row_addr;
				else if (mode == ttx_pkg::MODE_ROW_ZERO && adr == ttx_pkg::ROW_ADDR_ZERO)
					current_row_q <= 5'd0;
			end
		end
	end
endmodule

// ----- src/ttx_queue.sv -----
// Short queue between the front part and the back part.
module ttx_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ttx_pkg::item_t push_item,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output ttx_pkg::item_t head
);
	ttx_pkg::item_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head = mem_q[rd_q];

	// Storage: payload only.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- src/ttx_back.sv -----
// Back part: looks up the glyph and holds the result in the output register.
module ttx_back (
	input  logic clk,
	input  logic arst_n,
	input  logic use_latin1,
	input  logic not_empty,
	input  ttx_pkg::item_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [18:0] out_data
);
	logic [15:0] comp;
	logic [7:0] glyph;

	assign comp = ttx_pkg::compose(head.mark, head.data);
	always_comb begin
		if (head.op == ttx_pkg::OP_G2)
			glyph = use_latin1 ? ttx_pkg::g2_lat1(head.data) : ttx_pkg::g2_lat2(head.data);
		else
			glyph = use_latin1 ? comp[15:8] : comp[7:0];
	end

	assign pop = not_empty && (!out_valid || out_ready);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_data <= {glyph, head.column, head.row};
	end
endmodule

// ----- src/teletext_enhancement_triplet_decoder_core.sv -----
// Top level: teletext enhancement triplet decoder.
// Input stream s_axis: one triplet per transaction; tdata[17:0] triplet_word,
// tuser start_of_set. Output stream m_axis: one page character write per
// transaction; tdata[4:0] write_row, [10:5] write_column, [18:11] glyph_byte.
// Configuration: cfg_valid/cfg_ready write use_latin1_tables (reset 1).
// A triplet is taken every cycle while the two-entry queue has room. Fillers,
// row moves and off-page writes give no output. A write reaches m_axis through
// the queue and then the output register: it sits in the queue until the output
// register is free, and its glyph is then looked up into the output register.
// Unstalled throughput is one triplet per cycle, set by the single lookup stage.
// When the receiver stalls, the output register holds, the queue fills, and
// s_axis_tready falls once both queue entries are occupied.
// Reset clears the row to 0, empties the queue and output, and selects Latin-1.
module teletext_enhancement_triplet_decoder_core #(
	parameter int PAGE_COLUMNS = 40,
	parameter int PAGE_ROWS = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata, // triplet_word[17:0], zero fill
	input  logic s_axis_tuser,        // start_of_set
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // write_row, write_column, glyph_byte, zero fill
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);
	logic use_latin1_q;
	logic push, pop, full, not_empty;
	ttx_pkg::item_t push_item, head;
	logic [18:0] out_data;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) use_latin1_q <= 1'b1;
		else if (cfg_valid) use_latin1_q <= cfg_data;
	end

	ttx_front #(.PAGE_COLUMNS(PAGE_COLUMNS), .PAGE_ROWS(PAGE_ROWS)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .triplet_word(s_axis_tdata[17:0]),
		.start_of_set(s_axis_tuser), .in_ready(s_axis_tready), .push, .push_item,
		.q_full(full)
	);

	ttx_queue u_queue (
		.clk, .arst_n, .push, .push_item, .full, .pop, .not_empty, .head
	);

	ttx_back u_back (
		.clk, .arst_n, .use_latin1(use_latin1_q), .not_empty, .head, .pop,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data
	);

	assign m_axis_tdata = {5'd0, out_data};

	// A held result must stay stable while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	// Every write leaves with a column and row inside the page.
	a_page: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(m_axis_tdata[10:5]) < PAGE_COLUMNS
			&& 32'(m_axis_tdata[4:0]) < PAGE_ROWS)
		else $error("write outside page");
	// The queue never takes an entry while full.
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue overflow");
endmodule

// ----- tb/teletext_enhancement_triplet_decoder_core_tb.sv -----
// Testbench of the teletext enhancement triplet decoder: directed and random triplets, scored against a local predictor.
module teletext_enhancement_triplet_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One page character write as seen on the output stream, row in the lowest bits.
	typedef struct packed {
		logic [7:0] glyph;
		logic [5:0] column;
		logic [4:0] row;
	} page_write_t;

	// Predicts page writes and compares them with what the block sends.
	class page_write_board;
		bit latin1;
		logic [4:0] row_now;
		page_write_t pending[$];
		int errors;

		function void clear();
			latin1 = 1'b1;
			row_now = '0;
			pending.delete();
			errors = 0;
		endfunction

		// G2 glyph for data 32..127.
		function logic [7:0] g2_glyph(logic [6:0] d);
			byte unsigned t1[96] = '{
				8'h20,8'hA1,8'hA2,8'hA3,8'h24,8'hA5,8'h23,8'hA7,8'hA4,8'h27,8'h22,8'hAB,8'h20,8'h20,8'h20,8'h20,
				8'hB0,8'hB1,8'hB2,8'hB3,8'hD7,8'hB5,8'hB6,8'hB7,8'hF7,8'h27,8'h22,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF,
				8'h20,8'h60,8'hB4,8'h5E,8'h7E,8'h20,8'h20,8'h20,8'hA8,8'h2E,8'hB0,8'hB8,8'h5F,8'h22,8'h20,8'h20,
				8'h5F,8'hB9,8'hAE,8'hA9,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
				8'h20,8'hC6,8'hD0,8'hAA,8'h48,8'h20,8'h49,8'h4C,8'h4C,8'hD8,8'h20,8'hBA,8'hDE,8'h54,8'h4E,8'h6E,
				8'h4B,8'hE6,8'h64,8'hF0,8'h68,8'h69,8'h69,8'h6C,8'h6C,8'hF8,8'h20,8'hDF,8'hFE,8'h74,8'h6E,8'h7F};
			byte unsigned t2[96] = '{
				8'h20,8'h69,8'h63,8'h4C,8'h24,8'h59,8'h23,8'hA7,8'hA4,8'h27,8'h22,8'h3C,8'h20,8'h20,8'h20,8'h20,
				8'hB0,8'h20,8'h20,8'h20,8'hD7,8'h75,8'h20,8'h20,8'hF7,8'h27,8'h22,8'h3E,8'h20,8'h20,8'h20,8'h20,
				8'h20,8'h60,8'hB4,8'h5E,8'h7E,8'h20,8'hA2,8'hFF,8'hA8,8'h2E,8'hB0,8'hB8,8'h5F,8'hBD,8'hB2,8'hB7,
				8'h2D,8'h20,8'h52,8'h43,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
				8'h20,8'h20,8'hD0,8'h61,8'h48,8'h20,8'h69,8'h4C,8'hA3,8'h4F,8'h20,8'h6F,8'h70,8'h54,8'h4E,8'h6E,
				8'h4B,8'h20,8'hF0,8'h64,8'h68,8'h69,8'h69,8'h6C,8'hB3,8'h6F,8'h20,8'hDF,8'h70,8'h74,8'h6E,8'h7F};
			return latin1 ? t1[d - 32] : t2[d - 32];
		endfunction

		// Diacritical composition; characters without an entry pass through.
		function logic [7:0] accent(logic [3:0] m, logic [6:0] c);
			byte unsigned start[17] = '{0,1,12,37,48,55,55,57,59,69,69,74,80,81,86,90,108};
			string bases = {"#", " aeiouAEIOU", " aceilnorsuyzACEILNORSUYZ", " aeiouAEIOU",
				" anoANO", "aA", "zZ", "aeiouAEIOU", " auAU", "cstCST", " ", " ouOU",
				"aeAE", "cdelnrstzCDELNRSTZ"};
			byte unsigned l1[108] = '{8'hA4,
				8'h60,8'hE0,8'hE8,8'hEC,8'hF2,8'hF9,8'hC0,8'hC8,8'hCC,8'hD2,8'hD9,
				8'h27,8'hE1,"c",8'hE9,8'hED,"l","n",8'hF3,"r","s",8'hFA,8'hFD,"z",
				8'hC1,"C",8'hC9,8'hCD,"L","N",8'hD3,"R","S",8'hDA,8'hDD,"Z",
				8'h5E,8'hE2,8'hEA,8'hEE,8'hF4,8'hFB,8'hC2,8'hCA,8'hCE,8'hD4,8'hDB,
				8'h7E,8'hE3,8'hF1,8'hF5,8'hC3,8'hD1,8'hD5, "a","A", "z","Z",
				8'hE4,8'hEB,8'hEF,8'hF6,8'hFC,8'hC4,8'hCB,8'hCF,8'hD6,8'hDC,
				8'hB0,8'hE5,"u",8'hC5,"U", 8'hE7,"s","t",8'hC7,"S","T", 8'h5F,
				8'h22,"o","u","O","U", "a","e","A","E",
				"c","d","e","l","n","r","s","t","z","C","D","E","L","N","R","S","T","Z"};
			byte unsigned l2[108] = '{"$",
				8'h60,"a","e","i","o","u","A","E","I","O","U",
				8'h27,8'hE1,8'hE6,8'hE9,8'hED,8'hE5,8'hF1,8'hF3,8'hE0,8'hB6,8'hFA,8'hFD,8'hBC,
				8'hC1,8'hC6,8'hC9,8'hCD,8'hC5,8'hD1,8'hD3,8'hC0,8'hA6,8'hDA,8'hDD,8'hAC,
				8'h5E,8'hE2,"e",8'hEE,8'hF4,"u",8'hC2,"E",8'hCE,8'hD4,"U",
				8'h7E,"a","n","o","A","N","O", 8'hE3,8'hC3, 8'hBF,8'hAF,
				8'hE4,8'hEB,"i",8'hF6,8'hFC,8'hC4,8'hCB,"I",8'hD6,8'hDC,
				8'hB0,"a",8'hF9,"A",8'hD9, 8'hE7,8'hBA,8'hFE,8'hC7,8'hAA,8'hDE, 8'h5F,
				8'h22,8'hF5,8'hFB,8'hD5,8'hDB, 8'hB1,8'hEA,8'hA1,8'hCA,
				8'hE8,8'hEF,8'hEC,8'hB5,8'hF2,8'hF8,8'hB9,8'hBB,8'hBE,
				8'hC8,8'hCF,8'hCC,8'hA5,8'hD2,8'hD8,8'hA9,8'hAB,8'hAE};
			for (int i = start[m]; i < start[m + 1]; i++)
				if (bases[i] == {1'b0, c})
					return latin1 ? l1[i] : l2[i];
			return {1'b0, c};
		endfunction

		// Notes one accepted triplet and queues the write it causes, if any.
		function void note_triplet(logic [17:0] word, bit set_start);
			logic [5:0] adr;
			logic [4:0] mode;
			logic [6:0] data;
			logic [4:0] target;
			page_write_t w;
			adr = word[5:0];
			mode = word[10:6];
			data = word[17:11];
			if (set_start)
				row_now = '0;
			if (word[10:0] == 11'h7FF)
				return;
			if (adr >= ttx_pkg::ROW_ADDR_BASE) begin
				target = (adr == ttx_pkg::ROW_ADDR_BASE) ? ttx_pkg::LAST_ROW
					: 5'(adr - ttx_pkg::ROW_ADDR_BASE);
				if (mode == ttx_pkg::MODE_ROW_SET_A || mode == ttx_pkg::MODE_ROW_SET_B)
					row_now = target;
				else if (mode == ttx_pkg::MODE_ROW_ZERO && adr == ttx_pkg::ROW_ADDR_ZERO)
					row_now = '0;
				return;
			end
			if (mode == ttx_pkg::MODE_G2) begin
				if (data < 32)
					return;
				w.glyph = g2_glyph(data);
			end else if (mode >= 16) begin
				w.glyph = accent(mode[3:0], data);
			end else begin
				return;
			end
			if (row_now >= 25)
				return;
			w.row = row_now;
			w.column = adr;
			pending.push_back(w);
		endfunction

		// Compares one received write with the oldest expectation.
		function void check_write(page_write_t got);
			page_write_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected write, actual row %0d col %0d glyph %h",
					$time, got.row, got.column, got.glyph);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.row !== want.row)
				$display("%0t: row mismatch, expected %0d actual %0d", $time, want.row, got.row);
			if (got.column !== want.column)
				$display("%0t: column mismatch, expected %0d actual %0d",
					$time, want.column, got.column);
			if (got.glyph !== want.glyph)
				$display("%0t: glyph mismatch, expected %h actual %h",
					$time, want.glyph, got.glyph);
			if (got !== want)
				errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // triplet_word[17:0], zero fill
	logic s_axis_tuser = 1'b0;       // start_of_set
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // write_row, write_column, glyph_byte, zero fill
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	page_write_board board;
	int unsigned cycle_count = 0;
	int unsigned hold_off = 0;
	bit long_hold = 1'b0;

	teletext_enhancement_triplet_decoder_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Timeout guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_write(m_axis_tdata[18:0]);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				hold_off <= hold_off + 1;
				if (hold_off >= 60)
					long_hold <= 1'b0;
			end else begin
				hold_off <= 0;
				m_axis_tready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	// Random gap before an item, mostly short; the input idles during the gap.
	task automatic sender_gap();
		int n;
		n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1) : $urandom_range(2, 20);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0)
			s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offers one triplet and waits until it is accepted; valid stays up for the next one.
	task automatic send_triplet(logic [17:0] word, bit set_start, bit gaps);
		if (gaps)
			sender_gap();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, word};
		s_axis_tuser <= set_start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_triplet(word, set_start);
	endtask

	// Idles the input, waits until every expected write has arrived, then lets the pipe settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Writes the table selection while the block is idle.
	task automatic write_table_select(bit latin1);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= latin1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		board.latin1 = latin1;
	endtask

	function automatic logic [17:0] triplet(logic [6:0] d, logic [4:0] m, logic [5:0] a);
		return {d, m, a};
	endfunction

	// Mostly well-formed triplets: row moves, G2 and composed writes.
	function automatic logic [17:0] random_triplet();
		int k;
		string letters;
		k = $urandom_range(0, 99);
		letters = " #aAcCdDeEiIlLnNoOrRsStTuUyYzZ";
		if (k < 15)
			return triplet(7'($urandom),
				($urandom_range(0, 1) ? ttx_pkg::MODE_ROW_SET_A : ttx_pkg::MODE_ROW_SET_B),
				6'($urandom_range(40, 63)));
		if (k < 18)
			return triplet(7'($urandom), ttx_pkg::MODE_ROW_ZERO, ttx_pkg::ROW_ADDR_ZERO);
		if (k < 40)
			return triplet(7'($urandom), ttx_pkg::MODE_G2, 6'($urandom_range(0, 39)));
		if (k < 75)
			return triplet(7'(letters[$urandom_range(0, letters.len() - 1)]),
				5'($urandom_range(16, 31)), 6'($urandom_range(0, 39)));
		if (k < 78)
			return {7'($urandom_range(0, 127)), 11'h7FF};
		return 18'($urandom);
	endfunction

	initial begin
		logic [17:0] w;
		board = new();
		board.clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, filler, row addressing, several marks.
		send_triplet(triplet(7'd127, ttx_pkg::MODE_G2, 6'd0), 1'b1, 1'b0);
		send_triplet(triplet(7'd32, ttx_pkg::MODE_G2, 6'd39), 1'b0, 1'b0);
		send_triplet(triplet(7'd31, ttx_pkg::MODE_G2, 6'd5), 1'b0, 1'b0);
		send_triplet(18'h3FFFF, 1'b0, 1'b0);
		send_triplet(triplet(7'd0, ttx_pkg::MODE_ROW_SET_A, 6'd40), 1'b0, 1'b0);
		send_triplet(triplet(7'("a"), 5'd17, 6'd3), 1'b0, 1'b0);
		send_triplet(triplet(7'd0, ttx_pkg::MODE_ROW_SET_B, 6'd63), 1'b0, 1'b0);
		send_triplet(triplet(7'("#"), 5'd16, 6'd39), 1'b0, 1'b0);
		send_triplet(triplet(7'd0, ttx_pkg::MODE_ROW_ZERO, 6'd63), 1'b0, 1'b0);
		send_triplet(triplet(7'd0, ttx_pkg::MODE_ROW_ZERO, 6'd50), 1'b0, 1'b0);
		send_triplet(triplet(7'("a"), 5'd21, 6'd7), 1'b0, 1'b0);
		send_triplet(triplet(7'("a"), 5'd25, 6'd8), 1'b0, 1'b0);
		send_triplet(triplet(7'd65, 5'd3, 6'd9), 1'b0, 1'b0);
		send_triplet(triplet(7'("Z"), 5'd31, 6'd10), 1'b0, 1'b0);
		send_triplet(triplet(7'd0, ttx_pkg::MODE_ROW_SET_A, 6'd41), 1'b0, 1'b0);
		send_triplet(triplet(7'("z"), 5'd23, 6'd1), 1'b1, 1'b0);
		write_table_select(1'b0);
		send_triplet(triplet(7'd127, ttx_pkg::MODE_G2, 6'd0), 1'b0, 1'b0);
		send_triplet(triplet(7'("c"), 5'd31, 6'd2), 1'b0, 1'b0);
		send_triplet(triplet(7'("e"), 5'd30, 6'd4), 1'b0, 1'b0);
		send_triplet(triplet(7'd70, ttx_pkg::MODE_G2, 6'd6), 1'b0, 1'b0);

		// Random phases, alternating tables; one with a long receiver hold-off.
		for (int phase = 0; phase < 6; phase++) begin
			write_table_select(phase[0]);
			if (phase == 2)
				long_hold <= 1'b1;
			for (int i = 0; i < 300; i++) begin
				w = random_triplet();
				send_triplet(w, ($urandom_range(0, 29) == 0), (phase != 3));
			end
			// Sender pauses until every write has come.
			drain();
		end

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- teletext_enhancement_triplet_decoder_core.f -----
src/ttx_pkg.sv
src/ttx_front.sv
src/ttx_queue.sv
src/ttx_back.sv
src/teletext_enhancement_triplet_decoder_core.sv
tb/teletext_enhancement_triplet_decoder_core_tb.sv
